// ----- hdl/contact_force_coulomb_friction_macros.svh -----
// Assertion macros shared by the contact force block
`ifndef CONTACT_FORCE_COULOMB_FRICTION_MACROS_SVH
`define CONTACT_FORCE_COULOMB_FRICTION_MACROS_SVH
// Antecedent implies consequent on the same edge
`define CFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent on the next edge
`define CFC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants and helpers for the contact force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package cfc_pkg;
  localparam int FracBitsDefault = 16;
  localparam int SqrtSteps = 32;
  localparam int DivSteps = 32;
  localparam int Depth = 5 + SqrtSteps + DivSteps;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    begin
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/cfc_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// cfc_sqrt_stage
// One registered digit step of the restoring integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module cfc_sqrt_stage #(
  parameter int Step = 0
) (
  input  wire logic        clk,
  input  wire logic [65:0] rem_in,
  input  wire logic [32:0] root_in,
  output logic      [65:0] rem_out,
  output logic      [32:0] root_out
);
  localparam int Sh = 2 * (31 - Step);
  logic [65:0] trial;
  logic [65:0] rem_next;
  logic [32:0] root_next;

  // Try the next root bit and keep it if the remainder allows
  always_comb begin
    trial = ({33'd0, root_in} << (Sh + 2)) | (66'd1 << Sh);
    if (rem_in >= trial) begin
      rem_next = rem_in - trial;
      root_next = (root_in << 1) | 33'd1;
    end else begin
      rem_next = rem_in;
      root_next = root_in << 1;
    end
  end

  always_ff @(posedge clk) begin
    rem_out <= rem_next;
    root_out <= root_next;
  end
endmodule
`default_nettype wire

// ----- hdl/cfc_div_stage.sv -----
// ----------------------------------------------------------------------------
// cfc_div_stage
// One registered bit step of the two restoring quotient dividers.
// ----------------------------------------------------------------------------
`default_nettype none
module cfc_div_stage #(
  parameter int Step = 0
) (
  input  wire logic        clk,
  input  wire logic [63:0] num_x_in,
  input  wire logic [63:0] num_y_in,
  input  wire logic [32:0] den,
  input  wire logic [32:0] q_x_in,
  input  wire logic [32:0] q_y_in,
  output logic      [32:0] q_x_out,
  output logic      [32:0] q_y_out,
  output logic      [63:0] num_x_out,
  output logic      [63:0] num_y_out
);
  localparam int Sh = 31 - Step;
  logic [96:0] tx, ty, dsh;

  // Subtract shifted divisor where it fits
  always_comb begin
    dsh = {64'd0, den} << Sh;
    tx = {33'd0, num_x_in};
    ty = {33'd0, num_y_in};
  end

  always_ff @(posedge clk) begin
    if (tx >= dsh) begin
      num_x_out <= 64'(tx - dsh);
      q_x_out <= (q_x_in << 1) | 33'd1;
    end else begin
      num_x_out <= num_x_in;
      q_x_out <= q_x_in << 1;
    end
    if (ty >= dsh) begin
      num_y_out <= 64'(ty - dsh);
      q_y_out <= (q_y_in << 1) | 33'd1;
    end else begin
      num_y_out <= num_y_in;
      q_y_out <= q_y_in << 1;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/contact_force_coulomb_friction.sv -----
// ----------------------------------------------------------------------------
// contact_force_coulomb_friction
// Linear spring contact force with a Coulomb friction cap, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: drive the contact fields and pulse start; busy is always low, so a
// transaction is taken on every cycle start is high. Each result appears for
// one cycle with done high, after passing through the cfc_pkg::Depth stages:
// four arithmetic stages, one dividend stage, 32 square root digit stages
// and 32 divider bit stages. Throughput is one contact per cycle; the
// pipeline has no feedback.
// Reset clears the valid bits only, so no stray done follows reset. The
// receiver cannot stall, so results are never held: done marks one cycle.
// The capped quotients are floor(|c| * limit / mag), with 33-bit operands
// split into the 32 registered divider steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contact_force_coulomb_friction_macros.svh"
module contact_force_coulomb_friction #(
  parameter int FRAC_BITS = cfc_pkg::FracBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] old_tan_force_x,
  input  wire logic signed [31:0] old_tan_force_y,
  input  wire logic signed [31:0] disp_step_x,
  input  wire logic signed [31:0] disp_step_y,
  input  wire logic        [30:0] normal_stiffness,
  input  wire logic        [30:0] shear_stiffness,
  input  wire logic signed [31:0] overlap,
  input  wire logic        [30:0] friction_tan_a,
  input  wire logic        [30:0] friction_tan_b,
  input  wire logic               bond_failed,
  output logic                    done,
  output logic signed [31:0]      normal_load,
  output logic signed [31:0]      tan_force_x,
  output logic signed [31:0]      tan_force_y,
  output logic                    sliding_now,
  output logic                    failure_mark
);
  localparam int SQ = cfc_pkg::SqrtSteps;
  localparam int DV = cfc_pkg::DivSteps;
  localparam int D = cfc_pkg::Depth;

  // Per-stage sideband carried alongside the data
  typedef struct packed {
    logic               failed;
    logic signed [31:0] fn;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic        [31:0] fsum;
  } side_t;

  logic [D-1:0] vld;
  assign busy = 1'b0;

  // Stage 1: products
  logic signed [63:0] p_n, p_x, p_y;
  side_t s1;
  always_ff @(posedge clk) begin
    p_n <= $signed({1'b0, normal_stiffness}) * overlap;
    p_x <= $signed({1'b0, shear_stiffness}) * disp_step_x;
    p_y <= $signed({1'b0, shear_stiffness}) * disp_step_y;
    s1.failed <= bond_failed;
    s1.fn <= '0;
    s1.tx <= old_tan_force_x;
    s1.ty <= old_tan_force_y;
    s1.fsum <= {1'b0, friction_tan_a} + {1'b0, friction_tan_b};
  end

  // Stage 2: shift, subtract and saturate
  side_t s2;
  always_ff @(posedge clk) begin
    s2.failed <= s1.failed;
    s2.fsum <= s1.fsum;
    s2.fn <= cfc_pkg::sat32(66'(p_n >>> FRAC_BITS));
    if (s1.failed) begin
      s2.tx <= cfc_pkg::sat32(66'(s1.tx) - 66'(p_x >>> FRAC_BITS));
      s2.ty <= cfc_pkg::sat32(66'(s1.ty) - 66'(p_y >>> FRAC_BITS));
    end else begin
      s2.tx <= s1.tx;
      s2.ty <= s1.ty;
    end
  end

  // Stage 3: squares and friction product
  logic [63:0] sq_x, sq_y, p_f;
  logic [31:0] ax2, ay2;
  side_t s3;
  always_comb begin
    ax2 = s2.tx[31] ? 32'(-s2.tx) : 32'(s2.tx);
    ay2 = s2.ty[31] ? 32'(-s2.ty) : 32'(s2.ty);
  end
  always_ff @(posedge clk) begin
    sq_x <= ax2 * ax2;
    sq_y <= ay2 * ay2;
    p_f <= (s2.fn > 0) ? s2.fsum * 32'(s2.fn) : 64'd0;
    s3 <= s2;
  end

  // Stage 4: sum of squares and limit; clamp the limit at 33 bits, since
  // any larger limit already exceeds every possible magnitude
  logic [65:0] sum_sq;
  logic [32:0] lim4;
  side_t s4;
  always_ff @(posedge clk) begin
    sum_sq <= 66'(sq_x) + 66'(sq_y);
    if ((p_f >> (FRAC_BITS + 1)) > 64'h1_ffff_ffff) begin
      lim4 <= '1;
    end else begin
      lim4 <= 33'(p_f >> (FRAC_BITS + 1));
    end
    s4 <= s3;
  end

  // Square root digit stages
  logic [65:0] rem_a [SQ+1];
  logic [32:0] root_a [SQ+1];
  side_t ss [SQ+1];
  logic [32:0] lim_s [SQ+1];
  assign rem_a[0] = sum_sq;
  assign root_a[0] = '0;
  assign ss[0] = s4;
  assign lim_s[0] = lim4;
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    cfc_sqrt_stage #(.Step(i)) u_sq (
      .clk(clk), .rem_in(rem_a[i]), .root_in(root_a[i]),
      .rem_out(rem_a[i+1]), .root_out(root_a[i+1])
    );
    always_ff @(posedge clk) begin
      ss[i+1] <= ss[i];
      lim_s[i+1] <= lim_s[i];
    end
  end

  // Decide capping and form dividends
  logic [32:0] mag;
  logic        cap;
  logic [31:0] bx, by;
  assign mag = root_a[SQ];
  assign cap = ss[SQ].failed && (mag > lim_s[SQ]) && (mag != 33'd0);
  assign bx = ss[SQ].tx[31] ? 32'(-ss[SQ].tx) : 32'(ss[SQ].tx);
  assign by = ss[SQ].ty[31] ? 32'(-ss[SQ].ty) : 32'(ss[SQ].ty);

  logic [63:0] nx [DV+1];
  logic [63:0] ny [DV+1];
  logic [32:0] qx [DV+1];
  logic [32:0] qy [DV+1];
  logic [32:0] dd [DV+1];
  logic [DV:0] cp;
  side_t sd [DV+1];
  // Product |c|*limit is below 2^63 when capped, since limit < mag; quotient below 2^32
  always_ff @(posedge clk) begin
    nx[0] <= 64'(bx) * 64'(lim_s[SQ]);
    ny[0] <= 64'(by) * 64'(lim_s[SQ]);
    dd[0] <= cap ? mag : 33'd1;
    cp[0] <= cap;
    sd[0] <= ss[SQ];
  end
  assign qx[0] = '0;
  assign qy[0] = '0;
  for (genvar j = 0; j < DV; j++) begin : g_div
    cfc_div_stage #(.Step(j)) u_dv (
      .clk(clk), .num_x_in(nx[j]), .num_y_in(ny[j]), .den(dd[j]),
      .q_x_in(qx[j]), .q_y_in(qy[j]), .q_x_out(qx[j+1]), .q_y_out(qy[j+1]),
      .num_x_out(nx[j+1]), .num_y_out(ny[j+1])
    );
    always_ff @(posedge clk) begin
      dd[j+1] <= dd[j];
      cp[j+1] <= cp[j];
      sd[j+1] <= sd[j];
    end
  end

  // Output selection
  always_comb begin
    normal_load = sd[DV].fn;
    failure_mark = sd[DV].failed;
    sliding_now = cp[DV];
    if (cp[DV]) begin
      tan_force_x = sd[DV].tx[31] ? -$signed(qx[DV][31:0]) : $signed(qx[DV][31:0]);
      tan_force_y = sd[DV].ty[31] ? -$signed(qy[DV][31:0]) : $signed(qy[DV][31:0]);
    end else begin
      tan_force_x = sd[DV].tx;
      tan_force_y = sd[DV].ty;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[D-2:0], start};
    end
  end
  assign done = vld[D-1];

  `CFC_ASSERT_IMP(a_slide_needs_fail, clk, rst, done && sliding_now, failure_mark, "slide without failed bond")
  `CFC_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy, "busy raised")
  `CFC_ASSERT_NXT(a_valid_shift, clk, rst, vld[D-2], done, "valid bit lost")
endmodule
`default_nettype wire
